// File: sv/stxd_pkg.sv
// Shared types, constants and the hex digit decoder for the STX/ETX deframer.
// No dependencies.
package stxd_pkg;

  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 8;
  localparam int unsigned BiasW = 5;

  localparam logic [CfgIdxW-1:0] REG_START_BYTE  = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_END_BYTE    = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_LENGTH_BIAS = 2'd2;

  localparam logic [7:0] START_BYTE_RST = 8'h02;
  localparam logic [7:0] END_BYTE_RST = 8'h03;
  localparam logic [BiasW-1:0] LENGTH_BIAS_RST = 5'h1e;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_SHORT    = 3'd1;
  localparam logic [2:0] ST_MISMATCH = 3'd2;
  localparam logic [2:0] ST_LONG     = 3'd3;
  localparam logic [2:0] ST_BADHEX   = 3'd4;

  localparam int unsigned LenDigits = 4;
  localparam int unsigned HdrTotal = 6;

  typedef struct packed {
    logic [7:0]       start_byte;
    logic [7:0]       end_byte;
    logic [BiasW-1:0] length_bias;
  } stxd_cfg_t;

  typedef struct packed {
    logic [7:0]  payload_byte;
    logic        frame_end;
    logic [7:0]  cmd_code;
    logic [15:0] length_field;
    logic [2:0]  status;
  } stxd_res_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] nibble;
  } stxd_hex_t;

  function automatic stxd_hex_t hex_decode(logic [7:0] c);
    stxd_hex_t r;
    r.ok = 1'b1;
    if (c inside {[8'h30:8'h39]}) begin
      r.nibble = c[3:0];
    end else if (c inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
      r.nibble = 4'(c[2:0] + 3'd1) + 4'd8;
    end else begin
      r.ok = 1'b0;
      r.nibble = 4'd0;
    end
    return r;
  endfunction

endpackage

// File: sv/stxd_core.sv
// Frame tracker: hunt/in-frame state, header decode and result forming.
// Depends on stxd_pkg.
module stxd_core #(
  parameter int unsigned MAX_FRAME = 1024,
  parameter int unsigned MIN_BODY = 6
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               accept_i,
  input  logic [7:0]         rx_byte_i,
  input  stxd_pkg::stxd_cfg_t cfg_i,
  output logic               res_valid_o,
  output stxd_pkg::stxd_res_t res_o
);
  import stxd_pkg::*;

  localparam int unsigned CntW = ($clog2(MAX_FRAME) > $clog2(MIN_BODY + 1)) ?
                                 $clog2(MAX_FRAME) : $clog2(MIN_BODY + 1);
  localparam int unsigned ExpW = (CntW > 16 ? CntW : 16) + 2;
  localparam logic [CntW-1:0] BodyMax = CntW'(MAX_FRAME - 3);
  localparam logic [CntW-1:0] MinBody = CntW'(MIN_BODY);

  logic            in_frame_q, in_frame_d;
  logic [CntW-1:0] body_count_q, body_count_d;
  logic [15:0]     length_accum_q, length_accum_d;
  logic [7:0]      cmd_accum_q, cmd_accum_d;
  logic            hex_fault_q, hex_fault_d;

  stxd_hex_t        hex;
  logic signed [ExpW-1:0] expected;
  logic [2:0]       close_status;

  assign hex = hex_decode(rx_byte_i);
  assign expected = $signed({{(ExpW-CntW){1'b0}}, body_count_q}) +
                    ExpW'(signed'(cfg_i.length_bias));

  always_comb begin
    if (body_count_q < MinBody) begin
      close_status = ST_SHORT;
    end else if (hex_fault_q) begin
      close_status = ST_BADHEX;
    end else if (expected != $signed({{(ExpW-16){1'b0}}, length_accum_q})) begin
      close_status = ST_MISMATCH;
    end else begin
      close_status = ST_OK;
    end
  end

  always_comb begin
    in_frame_d = in_frame_q;
    body_count_d = body_count_q;
    length_accum_d = length_accum_q;
    cmd_accum_d = cmd_accum_q;
    hex_fault_d = hex_fault_q;
    res_valid_o = 1'b0;
    res_o.payload_byte = 8'd0;
    res_o.frame_end = 1'b0;
    res_o.cmd_code = cmd_accum_q;
    res_o.length_field = length_accum_q;
    res_o.status = ST_OK;
    if (accept_i) begin
      if (!in_frame_q) begin
        if (rx_byte_i == cfg_i.start_byte) begin
          in_frame_d = 1'b1;
          body_count_d = '0;
          length_accum_d = 16'd0;
          cmd_accum_d = 8'd0;
          hex_fault_d = 1'b0;
        end
      end else if (rx_byte_i == cfg_i.end_byte) begin
        res_valid_o = 1'b1;
        res_o.frame_end = 1'b1;
        res_o.status = close_status;
        in_frame_d = 1'b0;
      end else if (body_count_q >= BodyMax) begin
        res_valid_o = 1'b1;
        res_o.frame_end = 1'b1;
        res_o.status = ST_LONG;
        in_frame_d = 1'b0;
      end else begin
        body_count_d = body_count_q + 1'b1;
        if (body_count_q < CntW'(LenDigits)) begin
          length_accum_d = {length_accum_q[11:0], hex.nibble};
          hex_fault_d = hex_fault_q | ~hex.ok;
        end else if (body_count_q < CntW'(HdrTotal)) begin
          cmd_accum_d = {cmd_accum_q[3:0], hex.nibble};
          hex_fault_d = hex_fault_q | ~hex.ok;
        end else begin
          res_valid_o = 1'b1;
          res_o.payload_byte = rx_byte_i;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q <= 1'b0;
      body_count_q <= '0;
      length_accum_q <= 16'd0;
      cmd_accum_q <= 8'd0;
      hex_fault_q <= 1'b0;
    end else begin
      in_frame_q <= in_frame_d;
      body_count_q <= body_count_d;
      length_accum_q <= length_accum_d;
      cmd_accum_q <= cmd_accum_d;
      hex_fault_q <= hex_fault_d;
    end
  end

endmodule

// File: sv/stx_etx_hex_header_deframer_top.sv
// STX/ETX deframer with ASCII-hex length and command header: top level.
// Holds the configuration registers and the result register.
// Depends on stxd_pkg and stxd_core.
//
// Usage: feed received bytes on the input channel (in_valid_i/in_ready_o,
// rx_byte_i). Bytes are dropped until the start byte; the first four body
// bytes give the length, the next two the command; later body bytes come
// out one item each with frame_end_o low. The end byte, or a body that
// reaches MAX_FRAME-3 bytes followed by one more byte, gives a closing item
// with frame_end_o high and the status.
// Throughput: one byte per cycle unless stalled. Latency: a result item
// is valid on out_valid_o the cycle after its byte is accepted.
// Stall: the single result register holds its item while out_ready_i is
// low; in_ready_o stays high whenever that register is empty or being
// drained in the same cycle, so bytes that give no item still flow only
// then.
// Reset: the block hunts for a start byte and the configuration returns
// to start 0x02, end 0x03, length bias -2. Write cfg_* only while idle.
module stx_etx_hex_header_deframer_top #(
  parameter int unsigned MAX_FRAME = 1024,
  parameter int unsigned MIN_BODY = 6
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [stxd_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [stxd_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [7:0]                     rx_byte_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [7:0]                     payload_byte_o,
  output logic                           frame_end_o,
  output logic [7:0]                     cmd_code_o,
  output logic [15:0]                    length_field_o,
  output logic [2:0]                     status_o
);
  import stxd_pkg::*;

  stxd_cfg_t cfg_q;
  stxd_res_t res;
  stxd_res_t res_q;
  logic      res_valid;
  logic      out_valid_q;
  logic      accept;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_byte <= START_BYTE_RST;
      cfg_q.end_byte <= END_BYTE_RST;
      cfg_q.length_bias <= LENGTH_BIAS_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_START_BYTE:  cfg_q.start_byte <= cfg_data_i;
        REG_END_BYTE:    cfg_q.end_byte <= cfg_data_i;
        REG_LENGTH_BIAS: cfg_q.length_bias <= cfg_data_i[BiasW-1:0];
        default: ;
      endcase
    end
  end

  stxd_core #(
    .MAX_FRAME(MAX_FRAME),
    .MIN_BODY (MIN_BODY)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .rx_byte_i  (rx_byte_i),
    .cfg_i      (cfg_q),
    .res_valid_o(res_valid),
    .res_o      (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept && res_valid) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && res_valid) begin
      res_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign payload_byte_o = res_q.payload_byte;
  assign frame_end_o = res_q.frame_end;
  assign cmd_code_o = res_q.cmd_code;
  assign length_field_o = res_q.length_field;
  assign status_o = res_q.status;

endmodule

// File: dv/tb.sv
`timescale 1ns / 100ps
// Testbench for stx_etx_hex_header_deframer_top: byte stream in, payload and closing items out.
// A predictor tracks framing, header decode and status; results are checked in order.
// Depends on stxd_pkg and the deframer RTL.
module tb;
  import stxd_pkg::*;

  localparam int unsigned MaxFrame = 1024;
  localparam int unsigned MinBody = 6;
  localparam logic [CfgIdxW-1:0] REG_NONE = 2'd3;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  logic [7:0]          rx_byte_i = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic [7:0]          payload_byte_o;
  logic                frame_end_o;
  logic [7:0]          cmd_code_o;
  logic [15:0]         length_field_o;
  logic [2:0]          status_o;

  stx_etx_hex_header_deframer_top #(
    .MAX_FRAME(MaxFrame),
    .MIN_BODY (MinBody)
  ) i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .rx_byte_i     (rx_byte_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .payload_byte_o(payload_byte_o),
    .frame_end_o   (frame_end_o),
    .cmd_code_o    (cmd_code_o),
    .length_field_o(length_field_o),
    .status_o      (status_o)
  );

  always #5 clk_i = ~clk_i;

  // predictor state and configuration copy
  logic [7:0]       m_start = START_BYTE_RST;
  logic [7:0]       m_end = END_BYTE_RST;
  logic [BiasW-1:0] m_bias = LENGTH_BIAS_RST;
  logic             m_in_frame = 1'b0;
  logic [9:0]       m_count = '0;
  logic [15:0]      m_len = '0;
  logic [7:0]       m_cmd = '0;
  logic             m_badhex = 1'b0;

  stxd_res_t   frame_res_q[$];
  logic [7:0]  byte_q[$];
  int          n_pushed = 0;
  int          n_acc = 0;
  int          n_err = 0;
  int          rand_count = 0;
  int          in_max = 18;
  int          out_max = 18;
  int          in_gap = 0;
  int          out_gap = 0;
  int          out_hold = 0;
  logic        in_took = 1'b0;
  logic        out_took = 1'b0;
  logic        drv_v;
  logic        rcv_r;
  stxd_res_t   got;
  stxd_res_t   want;

  function automatic logic [3:0] digit_value(logic [7:0] c);
    logic [3:0] n;
    n = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) n = 4'(c - 8'h30);
    else if (c >= 8'h41 && c <= 8'h46) n = 4'(c - 8'h41 + 8'd10);
    else if (c >= 8'h61 && c <= 8'h66) n = 4'(c - 8'h61 + 8'd10);
    else m_badhex = 1'b1;
    return n;
  endfunction

  function automatic logic [2:0] close_code();
    int want_len;
    want_len = int'(m_count) + int'($signed(m_bias));
    if (m_count < MinBody) return ST_SHORT;
    if (m_badhex) return ST_BADHEX;
    if (want_len != int'(m_len)) return ST_MISMATCH;
    return ST_OK;
  endfunction

  function automatic void track_byte(logic [7:0] b);
    stxd_res_t r;
    int idx;
    r = '0;
    r.cmd_code = m_cmd;
    r.length_field = m_len;
    if (!m_in_frame) begin
      if (b == m_start) begin
        m_in_frame = 1'b1;
        m_count = '0;
        m_len = '0;
        m_cmd = '0;
        m_badhex = 1'b0;
      end
    end else if (b == m_end) begin
      r.frame_end = 1'b1;
      r.status = close_code();
      m_in_frame = 1'b0;
      frame_res_q.push_back(r);
    end else if (m_count >= MaxFrame - 3) begin
      r.frame_end = 1'b1;
      r.status = ST_LONG;
      m_in_frame = 1'b0;
      frame_res_q.push_back(r);
    end else begin
      idx = int'(m_count);
      m_count = m_count + 10'd1;
      if (idx < LenDigits) begin
        m_len = {m_len[11:0], digit_value(b)};
      end else if (idx < HdrTotal) begin
        m_cmd = {m_cmd[3:0], digit_value(b)};
      end else begin
        r.payload_byte = b;
        r.status = ST_OK;
        frame_res_q.push_back(r);
      end
    end
  endfunction

  // sample handshakes, check results, advance the predictor
  always @(posedge clk_i) begin
    if (rst_ni) begin
      in_took = in_valid_i && in_ready_o;
      out_took = out_valid_o && out_ready_i;
      if (out_took) begin
        got.payload_byte = payload_byte_o;
        got.frame_end = frame_end_o;
        got.cmd_code = cmd_code_o;
        got.length_field = length_field_o;
        got.status = status_o;
        if (frame_res_q.size() == 0) begin
          $display("%0t: unexpected item, expected none, got pb=%h fe=%b cmd=%h len=%h st=%0d",
                   $time, got.payload_byte, got.frame_end, got.cmd_code, got.length_field,
                   got.status);
          n_err++;
        end else begin
          want = frame_res_q.pop_front();
          if (got !== want) begin
            $display("%0t: mismatch, expected pb=%h fe=%b cmd=%h len=%h st=%0d, got pb=%h fe=%b cmd=%h len=%h st=%0d",
                     $time, want.payload_byte, want.frame_end, want.cmd_code,
                     want.length_field, want.status, got.payload_byte, got.frame_end,
                     got.cmd_code, got.length_field, got.status);
            n_err++;
          end
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_START_BYTE:  m_start = cfg_data_i;
          REG_END_BYTE:    m_end = cfg_data_i;
          REG_LENGTH_BIAS: m_bias = cfg_data_i[BiasW-1:0];
          default: ;
        endcase
      end
      if (in_took) begin
        track_byte(rx_byte_i);
        n_acc++;
      end
    end
  end

  // byte driver
  always @(negedge clk_i) begin
    if (rst_ni) begin
      drv_v = in_valid_i;
      if (drv_v && in_took) drv_v = 1'b0;
      if (!drv_v) begin
        if (in_gap > 0) begin
          in_gap--;
        end else if (byte_q.size() > 0) begin
          rx_byte_i <= byte_q.pop_front();
          drv_v = 1'b1;
          in_gap = $urandom_range(0, in_max);
        end
      end
      in_valid_i <= drv_v;
    end
  end

  // result receiver
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (out_hold > 0) begin
        out_hold--;
        rcv_r = 1'b0;
      end else begin
        if (out_took) out_gap = $urandom_range(0, out_max);
        if (out_gap > 0) begin
          out_gap--;
          rcv_r = 1'b0;
        end else begin
          rcv_r = 1'b1;
        end
      end
      out_ready_i <= rcv_r;
    end
  end

  function automatic void push_byte(logic [7:0] b);
    byte_q.push_back(b);
    n_pushed++;
  endfunction

  function automatic logic [7:0] hex_char(logic [3:0] n);
    if (n < 4'd10) return 8'h30 + 8'(n);
    if ($urandom_range(0, 1) == 1) return 8'h41 + 8'(n) - 8'd10;
    return 8'h61 + 8'(n) - 8'd10;
  endfunction

  function automatic bit is_hex(logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
           (c >= 8'h61 && c <= 8'h66);
  endfunction

  function automatic logic [7:0] body_byte();
    logic [7:0] c;
    c = 8'($urandom_range(0, 255));
    while (c == m_end) c = 8'($urandom_range(0, 255));
    return c;
  endfunction

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic settle();
    while (n_acc != n_pushed || frame_res_q.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic push_frame();
    int kind;
    int npay;
    int k;
    logic [15:0] lf;
    logic [7:0] cmd;
    logic [7:0] hdr[6];
    logic [7:0] c;
    kind = $urandom_range(0, 99);
    if (kind >= 86) begin
      repeat ($urandom_range(1, 4)) push_byte(8'($urandom_range(0, 255)));
    end else begin
      npay = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(0, 8);
      lf = 16'(6 + npay + int'($signed(m_bias)));
      if (kind >= 60 && kind < 70) lf = lf + 16'($urandom_range(1, 65535));
      cmd = 8'($urandom_range(0, 255));
      for (k = 0; k < 4; k++) hdr[k] = hex_char(lf[15-4*k -: 4]);
      hdr[4] = hex_char(cmd[7:4]);
      hdr[5] = hex_char(cmd[3:0]);
      if (kind >= 70 && kind < 78) begin
        c = body_byte();
        while (is_hex(c)) c = body_byte();
        hdr[$urandom_range(0, 5)] = c;
      end
      push_byte(m_start);
      rand_count++;
      if (kind >= 78 && kind < 86) begin
        for (k = 0; k < int'($urandom_range(0, 5)); k++) push_byte(hdr[k]);
        rand_count += k;
      end else begin
        for (k = 0; k < 6; k++) push_byte(hdr[k]);
        for (k = 0; k < npay; k++) begin
          c = ($urandom_range(0, 15) == 0 && m_start != m_end) ? m_start : body_byte();
          push_byte(c);
        end
        rand_count += 6 + npay;
      end
      push_byte(m_end);
      rand_count++;
    end
  endtask

  task automatic push_frames_to(int target);
    while (rand_count < target) push_frame();
  endtask

  // body of exactly MaxFrame-3 bytes; with overrun, one more byte closes it as too long
  task automatic push_long(bit overrun);
    int k;
    logic [15:0] lf;
    lf = 16'(int'(MaxFrame) - 3 + int'($signed(m_bias)));
    push_byte(m_start);
    for (k = 0; k < 4; k++) push_byte(hex_char(lf[15-4*k -: 4]));
    push_byte(8'h31);
    push_byte(8'h32);
    for (k = 0; k < int'(MaxFrame) - 3 - 6; k++) push_byte(body_byte());
    if (overrun) push_byte(8'h41);
    push_byte(m_end);
  endtask

  initial begin
    logic [7:0] s;
    logic [7:0] e;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: hunting noise, good frame, short frame, bad hex digit
    push_byte(8'h00);
    push_byte(8'hff);
    push_byte(8'h02);
    push_byte("0"); push_byte("0"); push_byte("0"); push_byte("7");
    push_byte("f"); push_byte("A");
    push_byte(8'h00); push_byte(8'hff); push_byte(8'h02);
    push_byte(8'h03);
    push_byte(8'h02); push_byte("1"); push_byte("2"); push_byte(8'h03);
    push_byte(8'h02); push_byte("G"); push_byte("0"); push_byte("0");
    push_byte("4"); push_byte("9"); push_byte("9"); push_byte(8'h03);
    settle();

    push_frames_to(150);
    settle();

    write_reg(REG_START_BYTE, 8'h00);
    write_reg(REG_END_BYTE, 8'hff);
    write_reg(REG_LENGTH_BIAS, {3'($urandom_range(0, 7)), 5'h18});
    in_max = 0;
    out_max = 0;
    out_hold = 400;
    push_frames_to(250);
    settle();

    write_reg(REG_START_BYTE, 8'hff);
    write_reg(REG_END_BYTE, 8'h00);
    write_reg(REG_LENGTH_BIAS, {3'($urandom_range(0, 7)), 5'h08});
    in_max = 18;
    out_max = 0;
    push_frames_to(350);
    settle();

    // start and end share a value
    write_reg(REG_START_BYTE, 8'h7e);
    write_reg(REG_END_BYTE, 8'h7e);
    write_reg(REG_LENGTH_BIAS, 8'h00);
    in_max = 0;
    out_max = 18;
    push_byte(8'h7e);
    push_byte("0"); push_byte("0"); push_byte("0"); push_byte("6");
    push_byte("1"); push_byte("2");
    push_byte(8'h7e);
    push_frames_to(450);
    settle();

    write_reg(REG_NONE, 8'($urandom_range(0, 255)));
    s = 8'($urandom_range(0, 255));
    e = 8'($urandom_range(0, 255));
    while (e == s) e = 8'($urandom_range(0, 255));
    write_reg(REG_START_BYTE, s);
    write_reg(REG_END_BYTE, e);
    write_reg(REG_LENGTH_BIAS, 8'(5'($signed($urandom_range(0, 16)) - 8)));
    in_max = 18;
    out_max = 18;
    push_frames_to(560);
    settle();

    write_reg(REG_START_BYTE, START_BYTE_RST);
    write_reg(REG_END_BYTE, END_BYTE_RST);
    write_reg(REG_LENGTH_BIAS, 8'(LENGTH_BIAS_RST));
    in_max = 0;
    out_max = 0;
    push_long(1'b0);
    push_long(1'b1);
    settle();
    in_max = 18;
    out_max = 18;
    push_frames_to(600);
    settle();

    repeat (10) @(negedge clk_i);
    if (n_err == 0 && frame_res_q.size() == 0) begin
      $display("stx_etx_hex_header_deframer_top test passed");
    end else begin
      $display("stx_etx_hex_header_deframer_top test failed");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("stx_etx_hex_header_deframer_top test failed");
    $finish;
  end

endmodule
